FILE: hw/rtl/obt_pkg.sv
// ----------------------------------------------------------------------------
// obt_pkg
// Types and constants shared by the oriented box transform blocks.
// ----------------------------------------------------------------------------
package obt_pkg;

	localparam int PROD_W      = 48;
	localparam int SUM_W       = 51;
	localparam int MAG_W       = 50;
	localparam int B_W         = 30;
	localparam int SQ_W        = 62;
	localparam int ROOT_W      = 31;
	localparam int REM_W       = MAG_W + 1;
	localparam int NUM_W       = MAG_W + 16;
	localparam int K_W         = 5;
	localparam int HPROD_W     = 63;
	localparam int ROOT_STEPS  = 31;
	localparam int DIV_STEPS   = 32;
	localparam int Q_DEPTH     = 4;
	localparam int Q_PTR_W     = 2;
	localparam int CFG_ADDR_W  = 3;
	localparam int CFG_DATA_W  = 64;

	localparam logic [63:0] ROW0_RST    = 64'h0000_0000_0000_1000;
	localparam logic [63:0] ROW1_RST    = 64'h0000_0000_1000_0000;
	localparam logic [63:0] ROW2_RST    = 64'h0000_1000_0000_0000;
	localparam logic [15:0] SHIFT_W_RST = 16'h1000;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_ROW0    = 3'd0,
		REG_ROW1    = 3'd1,
		REG_ROW2    = 3'd2,
		REG_SHIFT_X = 3'd3,
		REG_SHIFT_Y = 3'd4,
		REG_SHIFT_Z = 3'd5,
		REG_SHIFT_W = 3'd6
	} obt_reg_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_ZERO = 2'd1,
		ST_SAT  = 2'd2
	} obt_status_t;

	typedef struct packed {
		logic               mode;
		logic signed [31:0] in_x;
		logic signed [31:0] in_y;
		logic signed [31:0] in_z;
		logic [31:0]        half_in;
	} obt_in_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic [31:0]        half_out;
		logic [1:0]         status;
	} obt_out_t;

	typedef struct packed {
		logic [2:0][63:0] row;
		logic [2:0][31:0] shift;
		logic [15:0]      shift_w;
	} obt_cfg_t;

	typedef struct packed {
		logic                  mode;
		logic [2:0]            neg;
		logic                  wzero;
		logic [2:0]            ovf;
		logic [2:0]            nzero;
		logic [2:0][MAG_W-1:0] num;
		logic [MAG_W-1:0]      den;
		logic [K_W-1:0]        k;
		logic [31:0]           half;
		logic [SQ_W-1:0]       sq;
	} obt_item_t;

	typedef struct packed {
		obt_item_t       it;
		logic [SQ_W-1:0] v;
		logic [SQ_W-1:0] res;
	} obt_root_t;

	typedef struct packed {
		logic                  mode;
		logic [2:0]            neg;
		logic                  wzero;
		logic [2:0]            ovf;
		logic [2:0]            nzero;
		logic                  rzero;
		logic [K_W-1:0]        k;
		logic [HPROD_W-1:0]    prod;
		logic [MAG_W-1:0]      den;
		logic [2:0][REM_W-1:0] rem;
		logic [2:0][31:0]      nlo;
		logic [2:0][31:0]      quo;
	} obt_div_t;

endpackage

FILE: hw/rtl/obt_front.sv
// ----------------------------------------------------------------------------
// obt_front
// Matrix products, magnitudes, range checks and axis scaling; pushes items.
// ----------------------------------------------------------------------------
module obt_front import obt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  obt_in_t   in_data,
	input  obt_cfg_t  cfg,
	output logic      push,
	output obt_item_t push_item,
	input  logic      full
);

	logic adv;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	logic [2:0][3:0][PROD_W-1:0] prod_c, prod_s1;
	logic                        mode_s1, mode_s2;
	logic [31:0]                 half_s1, half_s2;
	logic [2:0][31:0]            vin;

	logic [3:0][SUM_W-1:0] acc_c;
	logic [2:0][SUM_W-1:0] val_c, val_s2;
	logic [SUM_W-1:0]      w_c, w_s2;

	obt_item_t        it3_c, item_s3, it4_c, item_s4, it5_c, item_s5, item_s6, it7_c, item_s7;
	logic [MAG_W-1:0] or_c, or_s3;
	logic [SUM_W-1:0] wmag_c;
	logic [2:0][SUM_W-1:0]   vmag_c;
	logic [2:0][2*B_W-1:0]   sqp_c, sqp_s6;

	assign adv       = !vld_s7 || !full;
	assign in_ready  = adv;
	assign push      = vld_s7 && !full;
	assign push_item = item_s7;
	assign vin       = {in_data.in_z, in_data.in_y, in_data.in_x};

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 4; c++) begin
				prod_c[r][c] = PROD_W'($signed(vin[r]) * $signed(cfg.row[r][16*c +: 16]));
			end
		end
	end

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			acc_c[c] = {{(SUM_W-PROD_W){prod_s1[0][c][PROD_W-1]}}, prod_s1[0][c]}
				+ {{(SUM_W-PROD_W){prod_s1[1][c][PROD_W-1]}}, prod_s1[1][c]}
				+ {{(SUM_W-PROD_W){prod_s1[2][c][PROD_W-1]}}, prod_s1[2][c]};
		end
		for (int j = 0; j < 3; j++) begin
			if (mode_s1) begin
				val_c[j] = acc_c[j];
			end else begin
				val_c[j] = acc_c[j]
					+ {{(SUM_W-44){cfg.shift[j][31]}}, cfg.shift[j], 12'b0};
			end
		end
		w_c = acc_c[3] + {{(SUM_W-32){cfg.shift_w[15]}}, cfg.shift_w, 16'b0};
	end

	always_comb begin
		it3_c  = '0;
		or_c   = '0;
		wmag_c = w_s2[SUM_W-1] ? SUM_W'(0) - w_s2 : w_s2;
		for (int j = 0; j < 3; j++) begin
			vmag_c[j]     = val_s2[j][SUM_W-1] ? SUM_W'(0) - val_s2[j] : val_s2[j];
			it3_c.num[j]  = vmag_c[j][MAG_W-1:0];
			it3_c.neg[j]  = mode_s2 ? val_s2[j][SUM_W-1]
				: (val_s2[j][SUM_W-1] ^ w_s2[SUM_W-1]);
			or_c          = or_c | vmag_c[j][MAG_W-1:0];
		end
		it3_c.mode  = mode_s2;
		it3_c.half  = half_s2;
		it3_c.den   = wmag_c[MAG_W-1:0];
		it3_c.wzero = (w_s2 == '0);
	end

	always_comb begin
		it4_c   = item_s3;
		it4_c.k = '0;
		for (int i = 0; i < MAG_W - B_W; i++) begin
			if (or_s3[B_W+i]) it4_c.k = K_W'(i + 1);
		end
		for (int j = 0; j < 3; j++) begin
			it4_c.ovf[j]   = {16'b0, item_s3.num[j]} >= {item_s3.den, 16'b0};
			it4_c.nzero[j] = (item_s3.num[j] == '0);
		end
	end

	always_comb begin
		it5_c = item_s4;
		for (int j = 0; j < 3; j++) begin
			if (item_s4.mode) it5_c.num[j] = item_s4.num[j] >> item_s4.k;
		end
	end

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			sqp_c[j] = item_s5.num[j][B_W-1:0] * item_s5.num[j][B_W-1:0];
		end
	end

	always_comb begin
		it7_c    = item_s6;
		it7_c.sq = SQ_W'(sqp_s6[0]) + SQ_W'(sqp_s6[1]) + SQ_W'(sqp_s6[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1 <= prod_c;
			mode_s1 <= in_data.mode;
			half_s1 <= in_data.half_in;
			val_s2  <= val_c;
			w_s2    <= w_c;
			mode_s2 <= mode_s1;
			half_s2 <= half_s1;
			item_s3 <= it3_c;
			or_s3   <= or_c;
			item_s4 <= it4_c;
			item_s5 <= it5_c;
			item_s6 <= item_s5;
			sqp_s6  <= sqp_c;
			item_s7 <= it7_c;
		end
	end

endmodule

FILE: hw/rtl/obt_queue.sv
// ----------------------------------------------------------------------------
// obt_queue
// Short item queue between the front and back pipelines.
// ----------------------------------------------------------------------------
module obt_queue import obt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  obt_item_t push_item,
	output logic      full,
	input  logic      pop,
	output obt_item_t pop_item,
	output logic      empty
);

	obt_item_t            mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [Q_PTR_W:0]     cnt_q;

	assign full     = (cnt_q == (Q_PTR_W+1)'(Q_DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + (Q_PTR_W+1)'(push) - (Q_PTR_W+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_item;
	end

endmodule

FILE: hw/rtl/obt_back.sv
// ----------------------------------------------------------------------------
// obt_back
// Pipelined square root, pipelined restoring divide, rounding and clamping.
// ----------------------------------------------------------------------------
module obt_back import obt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      empty,
	output logic      pop,
	input  obt_item_t item,
	output logic      out_valid,
	input  logic      out_ready,
	output obt_out_t  out_data
);

	function automatic obt_root_t root_step(obt_root_t x, logic [SQ_W-1:0] b);
		obt_root_t   y;
		logic [SQ_W:0] t;
		y = x;
		t = {1'b0, x.res} + {1'b0, b};
		if ({1'b0, x.v} >= t) begin
			y.v   = x.v - t[SQ_W-1:0];
			y.res = (x.res >> 1) + b;
		end else begin
			y.res = x.res >> 1;
		end
		return y;
	endfunction

	function automatic obt_div_t div_setup(obt_root_t x);
		obt_div_t            d;
		logic [ROOT_W-1:0]   r;
		logic [NUM_W-1:0]    n;
		r       = x.res[ROOT_W-1:0];
		d.mode  = x.it.mode;
		d.neg   = x.it.neg;
		d.wzero = x.it.wzero;
		d.ovf   = x.it.ovf;
		d.nzero = x.it.nzero;
		d.k     = x.it.k;
		d.rzero = (r == '0);
		d.prod  = HPROD_W'(x.it.half) * HPROD_W'(r);
		d.den   = x.it.mode ? MAG_W'(r) : x.it.den;
		for (int j = 0; j < 3; j++) begin
			n = {x.it.num[j], 16'b0} + (x.it.mode ? NUM_W'(r >> 1) : NUM_W'(0));
			d.rem[j] = REM_W'(n[NUM_W-1:32]);
			d.nlo[j] = n[31:0];
			d.quo[j] = '0;
		end
		return d;
	endfunction

	function automatic obt_div_t div_step(obt_div_t x);
		obt_div_t         y;
		logic [REM_W-1:0] t;
		y = x;
		for (int j = 0; j < 3; j++) begin
			t = {x.rem[j][REM_W-2:0], x.nlo[j][31]};
			if (t >= {1'b0, x.den}) begin
				y.rem[j] = t - {1'b0, x.den};
				y.quo[j] = {x.quo[j][30:0], 1'b1};
			end else begin
				y.rem[j] = t;
				y.quo[j] = {x.quo[j][30:0], 1'b0};
			end
			y.nlo[j] = {x.nlo[j][30:0], 1'b0};
		end
		return y;
	endfunction

	function automatic obt_out_t finish(obt_div_t d);
		obt_out_t         o;
		logic [2:0][31:0] res;
		logic             sat;
		logic [32:0]      q33;
		logic [REM_W:0]   rem2;
		logic [K_W-1:0]   sh;
		logic [63:0]      pr;
		obt_status_t      st;
		logic [31:0]      half;
		sat  = 1'b0;
		half = '0;
		st   = ST_OK;
		if (!d.mode) begin
			for (int j = 0; j < 3; j++) begin
				rem2 = {d.rem[j], 1'b0};
				q33  = {1'b0, d.quo[j]} + 33'(rem2 >= {2'b0, d.den});
				if (d.wzero) begin
					res[j] = d.nzero[j] ? 32'd0 : (d.neg[j] ? 32'h8000_0000 : 32'h7FFF_FFFF);
				end else if (d.nzero[j]) begin
					res[j] = 32'd0;
				end else if (d.ovf[j]) begin
					sat    = 1'b1;
					res[j] = d.neg[j] ? 32'h8000_0000 : 32'h7FFF_FFFF;
				end else if (d.neg[j]) begin
					if (q33 > 33'h0_8000_0000) begin
						sat    = 1'b1;
						res[j] = 32'h8000_0000;
					end else begin
						res[j] = 32'd0 - q33[31:0];
					end
				end else begin
					if (q33 > 33'h0_7FFF_FFFF) begin
						sat    = 1'b1;
						res[j] = 32'h7FFF_FFFF;
					end else begin
						res[j] = q33[31:0];
					end
				end
			end
			if (d.wzero) st = ST_ZERO;
			else if (sat) st = ST_SAT;
		end else if (d.rzero) begin
			res = '0;
			st  = ST_ZERO;
		end else begin
			for (int j = 0; j < 3; j++) begin
				res[j] = d.neg[j] ? 32'd0 - d.quo[j] : d.quo[j];
			end
			sh = K_W'(28) - d.k;
			pr = ({1'b0, d.prod} + (64'd1 << (sh - 1'b1))) >> sh;
			if (pr > 64'h0000_0000_FFFF_FFFF) begin
				half = 32'hFFFF_FFFF;
				st   = ST_SAT;
			end else begin
				half = pr[31:0];
			end
		end
		o.out_x    = res[0];
		o.out_y    = res[1];
		o.out_z    = res[2];
		o.half_out = half;
		o.status   = st;
		return o;
	endfunction

	logic      adv;
	obt_root_t root_in;
	obt_root_t root_q [ROOT_STEPS+1];
	logic      root_vld_q [ROOT_STEPS+1];
	obt_div_t  div_q [DIV_STEPS+1];
	logic      div_vld_q [DIV_STEPS+1];
	logic      out_vld_q;
	obt_out_t  out_q;

	assign adv       = !out_vld_q || out_ready;
	assign pop       = adv && !empty;
	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	always_comb begin
		root_in.it  = item;
		root_in.v   = item.sq;
		root_in.res = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= ROOT_STEPS; i++) root_vld_q[i] <= 1'b0;
			for (int i = 0; i <= DIV_STEPS; i++) div_vld_q[i] <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			root_vld_q[0] <= !empty;
			for (int i = 0; i < ROOT_STEPS; i++) root_vld_q[i+1] <= root_vld_q[i];
			div_vld_q[0] <= root_vld_q[ROOT_STEPS];
			for (int i = 0; i < DIV_STEPS; i++) div_vld_q[i+1] <= div_vld_q[i];
			out_vld_q <= div_vld_q[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			root_q[0] <= root_in;
			for (int i = 0; i < ROOT_STEPS; i++) begin
				root_q[i+1] <= root_step(root_q[i], SQ_W'(1) << (2 * (ROOT_STEPS - 1 - i)));
			end
			div_q[0] <= div_setup(root_q[ROOT_STEPS]);
			for (int i = 0; i < DIV_STEPS; i++) div_q[i+1] <= div_step(div_q[i]);
			out_q <= finish(div_q[DIV_STEPS]);
		end
	end

endmodule

FILE: hw/rtl/oriented_box_transform.sv
// ----------------------------------------------------------------------------
// oriented_box_transform
// Moves a box center or axis through a 4x4 row-vector matrix.
//
//   channel  dir  handshake            payload
//   in       in   in_valid/in_ready    obt_in_t  (mode, in_x/y/z, half_in)
//   out      out  out_valid/out_ready  obt_out_t (out_x/y/z, half_out, status)
//   cfg      in   cfg_we               cfg_addr, cfg_data (no read-back)
//
// One item per cycle while out_ready stays high; it passes 7 front stages,
// the queue, 32 square root stages, 33 divide stages and the output register.
// Reset clears all valid bits and loads the identity matrix.
// The front stalls only when the 4-entry queue is full; the back stalls only
// while the output register holds an item that is not taken.
// ----------------------------------------------------------------------------
module oriented_box_transform import obt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  obt_in_t               in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output obt_out_t              out_data,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	obt_cfg_t  cfg_q;
	logic      push, full, pop, empty;
	obt_item_t push_item, pop_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row[0]   <= ROW0_RST;
			cfg_q.row[1]   <= ROW1_RST;
			cfg_q.row[2]   <= ROW2_RST;
			cfg_q.shift    <= '0;
			cfg_q.shift_w  <= SHIFT_W_RST;
		end else if (cfg_we) begin
			unique case (obt_reg_t'(cfg_addr))
				REG_ROW0:    cfg_q.row[0]   <= cfg_data;
				REG_ROW1:    cfg_q.row[1]   <= cfg_data;
				REG_ROW2:    cfg_q.row[2]   <= cfg_data;
				REG_SHIFT_X: cfg_q.shift[0] <= cfg_data[31:0];
				REG_SHIFT_Y: cfg_q.shift[1] <= cfg_data[31:0];
				REG_SHIFT_Z: cfg_q.shift[2] <= cfg_data[31:0];
				REG_SHIFT_W: cfg_q.shift_w  <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	obt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.cfg       (cfg_q),
		.push      (push),
		.push_item (push_item),
		.full      (full)
	);

	obt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.pop_item  (pop_item),
		.empty     (empty)
	);

	obt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.pop       (pop),
		.item      (pop_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

FILE: tb/tb_oriented_box_transform.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_oriented_box_transform
// Drives centers and axes through the box transform under several matrices
// and random flow control; each output is checked in order against a queued
// value from a local fixed-point predictor or given in a directed vector.
// ----------------------------------------------------------------------------
module tb_oriented_box_transform;
	import obt_pkg::*;

	localparam int N_RANDOM = 1900;
	localparam int N_DIRECTED = 14;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	obt_in_t               in_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	obt_out_t              out_data;
	logic                  cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic [2:0][63:0] mat_rows;
	logic [2:0][31:0] mat_shift;
	logic [15:0]      mat_w;

	obt_out_t expected_q[$];
	int       errors = 0;
	bit       busy_phase = 1'b1;

	always #5 clk = ~clk;

	oriented_box_transform uut (.*);

	task automatic report(input string what, input obt_out_t got, input obt_out_t want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic longint lane_of(input logic [63:0] row, input int c);
		logic signed [15:0] v;
		v = row[16*c +: 16];
		return longint'(v);
	endfunction

	function automatic logic [63:0] umag(input longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic longint center_div(input longint num, input longint den, inout bit sat);
		logic [63:0] un, ud, q, r;
		bit neg;
		un = umag(num);
		ud = umag(den);
		neg = (num < 0) != (den < 0);
		if (un == 0) return 0;
		q = un / ud;
		r = un % ud;
		if (q >= 65536) begin
			sat = 1'b1;
			return neg ? -64'sd2147483648 : 64'sd2147483647;
		end
		for (int i = 0; i < 16; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= ud) begin
				r -= ud;
				q |= 1;
			end
		end
		if ((r << 1) >= ud) q++;
		if (neg) begin
			if (q > 64'd2147483648) begin
				sat = 1'b1;
				return -64'sd2147483648;
			end
			return -longint'(q);
		end
		if (q > 64'd2147483647) begin
			sat = 1'b1;
			return 64'sd2147483647;
		end
		return longint'(q);
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic obt_out_t transform_box(input obt_in_t it);
		longint v[3], a[4], res[3];
		logic [63:0] m, b[3], sq, r, q, p;
		longint w, n;
		int k, sh;
		bit sat;
		obt_out_t o;
		sat = 1'b0;
		o = '0;
		v[0] = longint'(it.in_x);
		v[1] = longint'(it.in_y);
		v[2] = longint'(it.in_z);
		for (int c = 0; c < 4; c++)
			a[c] = v[0] * lane_of(mat_rows[0], c) + v[1] * lane_of(mat_rows[1], c)
				+ v[2] * lane_of(mat_rows[2], c);
		if (!it.mode) begin
			w = a[3] + longint'($signed(mat_w)) * 65536;
			for (int c = 0; c < 3; c++) begin
				n = a[c] + longint'($signed(mat_shift[c])) * 4096;
				if (w == 0)
					res[c] = n > 0 ? 64'sd2147483647 : (n < 0 ? -64'sd2147483648 : 0);
				else
					res[c] = center_div(n, w, sat);
			end
			o.status = w == 0 ? ST_ZERO : (sat ? ST_SAT : ST_OK);
		end else begin
			m = 0;
			k = 0;
			sq = 0;
			for (int c = 0; c < 3; c++) if (umag(a[c]) > m) m = umag(a[c]);
			while ((m >> k) >= (64'd1 << 30)) k++;
			for (int c = 0; c < 3; c++) begin
				b[c] = umag(a[c]) >> k;
				sq += b[c] * b[c];
			end
			r = int_sqrt(sq);
			if (r == 0) begin
				res[0] = 0;
				res[1] = 0;
				res[2] = 0;
				o.status = ST_ZERO;
			end else begin
				for (int c = 0; c < 3; c++) begin
					q = (b[c] * 65536 + (r >> 1)) / r;
					res[c] = a[c] < 0 ? -longint'(q) : longint'(q);
				end
				p = 64'(it.half_in) * r;
				sh = 28 - k;
				p = (p + (64'd1 << (sh - 1))) >> sh;
				o.status = ST_OK;
				if (p > 64'hFFFF_FFFF) begin
					p = 64'hFFFF_FFFF;
					o.status = ST_SAT;
				end
				o.half_out = p[31:0];
			end
		end
		o.out_x = res[0][31:0];
		o.out_y = res[1][31:0];
		o.out_z = res[2][31:0];
		return o;
	endfunction

	task automatic write_reg(input obt_reg_t idx, input logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		case (idx)
			REG_ROW0: mat_rows[0] = val;
			REG_ROW1: mat_rows[1] = val;
			REG_ROW2: mat_rows[2] = val;
			REG_SHIFT_X: mat_shift[0] = val[31:0];
			REG_SHIFT_Y: mat_shift[1] = val[31:0];
			REG_SHIFT_Z: mat_shift[2] = val[31:0];
			REG_SHIFT_W: mat_w = val[15:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	function automatic bit gap_now;
		return !busy_phase && ($urandom_range(99) < 17);
	endfunction

	task automatic send_item(input obt_in_t it, input bit has_want, input obt_out_t want);
		while (gap_now()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		expected_q.push_back(has_want ? want : transform_box(it));
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord;
		case ($urandom_range(4))
			0: return $urandom;
			1: return 32'($signed($urandom_range(8000000)) - 4000000);
			2: return 32'($signed($urandom_range(600)) - 300) << 16;
			3: return '0;
			default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
		endcase
	endfunction

	function automatic logic [63:0] rand_row;
		logic [63:0] r;
		for (int c = 0; c < 4; c++)
			case ($urandom_range(3))
				0: r[16*c +: 16] = $urandom;
				1: r[16*c +: 16] = 16'($signed($urandom_range(8192)) - 4096);
				2: r[16*c +: 16] = '0;
				default: r[16*c +: 16] = 16'h1000;
			endcase
		return r;
	endfunction

	typedef struct {
		obt_in_t  it;
		bit       has_want;
		obt_out_t want;
	} vec_t;

	vec_t directed[N_DIRECTED];

	initial begin
		directed[0] = '{'{1'b0, 32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000, 32'h0},
			1'b1, '{32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000, 32'h0, ST_OK}};
		directed[1] = '{'{1'b1, 32'sh0001_0000, 32'sh0, 32'sh0, 32'h0005_0000},
			1'b1, '{32'sh0001_0000, 32'sh0, 32'sh0, 32'h0005_0000, ST_OK}};
		directed[2] = '{'{1'b1, 32'sh0, 32'sh0, 32'sh0, 32'hFFFF_FFFF},
			1'b1, '{32'sh0, 32'sh0, 32'sh0, 32'h0, ST_ZERO}};
		directed[3] = '{'{1'b0, 32'sh0, 32'sh0, 32'sh0, 32'hFFFF_FFFF},
			1'b1, '{32'sh0, 32'sh0, 32'sh0, 32'h0, ST_OK}};
		directed[4] = '{'{1'b0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'h0},
			1'b0, '0};
		directed[5] = '{'{1'b1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'hFFFF_FFFF},
			1'b0, '0};
		directed[6] = '{'{1'b1, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'h1},
			1'b0, '0};
		directed[7] = '{'{1'b1, 32'sh0, 32'sh0, -32'sh1, 32'h8000_0000}, 1'b0, '0};
		directed[8] = '{'{1'b0, -32'sh1, 32'sh1, 32'sh0, 32'h0}, 1'b0, '0};
		directed[9] = '{'{1'b1, 32'sh0003_0000, 32'sh0004_0000, 32'sh0, 32'h0001_0000},
			1'b0, '0};
		directed[10] = '{'{1'b0, 32'sh1234_5678, -32'sh0765_4321, 32'sh0000_0001, 32'h0},
			1'b0, '0};
		directed[11] = '{'{1'b1, 32'sh7FFF_FFFF, 32'sh0, 32'sh0, 32'hFFFF_FFFF}, 1'b0, '0};
		directed[12] = '{'{1'b1, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0, 32'h5555_5555},
			1'b0, '0};
		directed[13] = '{'{1'b0, 32'shAAAA_AAAA, 32'sh5555_5555, 32'sh0, 32'hAAAA_AAAA},
			1'b0, '0};
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				report("unexpected", out_data, '0);
			end else begin
				automatic obt_out_t want = expected_q.pop_front();
				if (out_data.out_x !== want.out_x) report("out_x", out_data, want);
				if (out_data.out_y !== want.out_y) report("out_y", out_data, want);
				if (out_data.out_z !== want.out_z) report("out_z", out_data, want);
				if (out_data.half_out !== want.half_out) report("half_out", out_data, want);
				if (out_data.status !== want.status) report("status", out_data, want);
			end
		end
		if (!arst_n) out_ready <= 1'b0;
		else out_ready <= !(!busy_phase && ($urandom_range(99) < 17));
	end

	initial begin
		obt_in_t it;
		mat_rows[0] = ROW0_RST;
		mat_rows[1] = ROW1_RST;
		mat_rows[2] = ROW2_RST;
		mat_shift = '0;
		mat_w = SHIFT_W_RST;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);
		busy_phase = 1'b0;
		for (int i = 0; i < N_DIRECTED; i++)
			send_item(directed[i].it, directed[i].has_want, directed[i].want);
		drain();
		// extreme matrix, then zero w plane
		write_reg(REG_ROW0, 64'h7FFF_8000_7FFF_8000);
		write_reg(REG_ROW1, 64'h8000_7FFF_8000_7FFF);
		write_reg(REG_ROW2, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_SHIFT_X, 64'h7FFF_FFFF);
		write_reg(REG_SHIFT_Y, 64'h8000_0000);
		write_reg(REG_SHIFT_Z, 64'hFFFF_FFFF);
		write_reg(REG_SHIFT_W, 64'h8000);
		for (int i = 4; i < N_DIRECTED; i++) send_item(directed[i].it, 1'b0, '0);
		drain();
		write_reg(REG_ROW0, 64'h0000_0000_0000_2000);
		write_reg(REG_ROW1, 64'h0000_0000_0800_0000);
		write_reg(REG_ROW2, 64'h0000_1000_0000_0000);
		write_reg(REG_SHIFT_W, 64'h0);
		for (int i = 0; i < N_DIRECTED; i++) send_item(directed[i].it, 1'b0, '0);
		drain();
		for (int ph = 0; ph < 6; ph++) begin
			if (ph > 0) begin
				write_reg(REG_ROW0, rand_row());
				write_reg(REG_ROW1, rand_row());
				write_reg(REG_ROW2, rand_row());
				write_reg(REG_SHIFT_X, {32'h0, rand_coord()});
				write_reg(REG_SHIFT_Y, {32'h0, rand_coord()});
				write_reg(REG_SHIFT_Z, {32'h0, rand_coord()});
				write_reg(REG_SHIFT_W, $urandom_range(3) == 0 ? 64'h0 : {48'h0, 16'($urandom)});
			end
			busy_phase = ph == 2;
			for (int i = 0; i < N_RANDOM / 6; i++) begin
				it.mode = 1'($urandom_range(1));
				it.in_x = rand_coord();
				it.in_y = rand_coord();
				it.in_z = rand_coord();
				it.half_in = $urandom_range(1) ? $urandom : $urandom_range(32'h0010_0000);
				send_item(it, 1'b0, '0);
			end
			busy_phase = 1'b0;
			drain();
		end
		if (errors == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end

	initial begin
		#5ms;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
